// ----- src/swq_pkg.sv -----
// shared types and constants for the skin weight quantizer
package swq_pkg;

    localparam int N_INF      = 4;
    localparam int Q_BITS     = 8;
    localparam int W_BITS     = 15;
    localparam int S_BITS     = 17;
    localparam int P_BITS     = 23;
    localparam int FULL_SCALE = 255;

    typedef struct packed {
        logic                              valid;
        logic [S_BITS-1:0]                 sum;
        logic [N_INF-1:0][7:0]             joint;
        logic [N_INF-1:0][P_BITS-1:0]      rem;
        logic [N_INF-1:0][Q_BITS-1:0]      q;
    } t_item;

endpackage

// ----- src/swq_sort.sv -----
// clamp register, sorting network and product setup for the divider chain
module swq_sort (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic [swq_pkg::N_INF-1:0][15:0]       i_joint,
    input  logic [swq_pkg::N_INF-1:0][15:0]       i_weight,
    output swq_pkg::t_item                        o_item
);
    import swq_pkg::*;

    logic                          r_valid;
    logic [N_INF-1:0][15:0]        r_joint;
    logic [N_INF-1:0][W_BITS-1:0]  r_weight;
    t_item                         r_item;
    t_item                         n_item;

    logic [N_INF-1:0][15:0]        s_j;
    logic [N_INF-1:0][W_BITS-1:0]  s_w;

    // lower position must come first: heavier, or equal and lower joint
    function automatic logic in_order(input logic [W_BITS-1:0] wa, input logic [15:0] ja,
                                      input logic [W_BITS-1:0] wb, input logic [15:0] jb);
        in_order = (wa > wb) || ((wa == wb) && (ja <= jb));
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_joint <= i_joint;
        for (int l = 0; l < N_INF; l++) begin
            r_weight[l] <= i_weight[l][15] ? '0 : i_weight[l][W_BITS-1:0];
        end
    end

    always_comb begin
        logic [W_BITS-1:0] tw;
        logic [15:0]       tj;
        logic [S_BITS-1:0] acc;
        tw  = '0;
        tj  = '0;
        s_j = r_joint;
        s_w = r_weight;
        // five comparator network for four entries
        if (!in_order(s_w[0], s_j[0], s_w[1], s_j[1])) begin
            tw = s_w[0]; s_w[0] = s_w[1]; s_w[1] = tw;
            tj = s_j[0]; s_j[0] = s_j[1]; s_j[1] = tj;
        end
        if (!in_order(s_w[2], s_j[2], s_w[3], s_j[3])) begin
            tw = s_w[2]; s_w[2] = s_w[3]; s_w[3] = tw;
            tj = s_j[2]; s_j[2] = s_j[3]; s_j[3] = tj;
        end
        if (!in_order(s_w[0], s_j[0], s_w[2], s_j[2])) begin
            tw = s_w[0]; s_w[0] = s_w[2]; s_w[2] = tw;
            tj = s_j[0]; s_j[0] = s_j[2]; s_j[2] = tj;
        end
        if (!in_order(s_w[1], s_j[1], s_w[3], s_j[3])) begin
            tw = s_w[1]; s_w[1] = s_w[3]; s_w[3] = tw;
            tj = s_j[1]; s_j[1] = s_j[3]; s_j[3] = tj;
        end
        if (!in_order(s_w[1], s_j[1], s_w[2], s_j[2])) begin
            tw = s_w[1]; s_w[1] = s_w[2]; s_w[2] = tw;
            tj = s_j[1]; s_j[1] = s_j[2]; s_j[2] = tj;
        end

        acc = '0;
        for (int l = 0; l < N_INF; l++) begin
            acc = acc + S_BITS'(r_weight[l]);
        end

        n_item.valid = r_valid;
        n_item.sum   = acc;
        for (int l = 0; l < N_INF; l++) begin
            n_item.joint[l] = s_j[l][7:0];
            // w*255 as (w << 8) - w
            n_item.rem[l]   = {s_w[l], 8'd0} - P_BITS'(s_w[l]);
            n_item.q[l]     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else begin
            r_item.valid <= n_item.valid;
        end
        r_item.sum   <= n_item.sum;
        r_item.joint <= n_item.joint;
        r_item.rem   <= n_item.rem;
        r_item.q     <= n_item.q;
    end

    assign o_item = r_item;

endmodule

// ----- src/swq_div_cell.sv -----
// one restoring division cell: resolves one quotient bit for all four lanes
module swq_div_cell #(
    parameter int BIT = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  swq_pkg::t_item  i_item,
    output swq_pkg::t_item  o_item
);
    import swq_pkg::*;

    t_item r_item;
    t_item n_item;

    always_comb begin
        logic [P_BITS:0] d;
        n_item = i_item;
        d = (P_BITS+1)'(i_item.sum) << BIT;
        for (int l = 0; l < N_INF; l++) begin
            if ({1'b0, i_item.rem[l]} >= d) begin
                n_item.rem[l]    = i_item.rem[l] - d[P_BITS-1:0];
                n_item.q[l][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else begin
            r_item.valid <= n_item.valid;
        end
        r_item.sum   <= n_item.sum;
        r_item.joint <= n_item.joint;
        r_item.rem   <= n_item.rem;
        r_item.q     <= n_item.q;
    end

    assign o_item = r_item;

endmodule

// ----- src/swq_round.sv -----
// leftover unit distribution by largest remainder and output register
module swq_round (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  swq_pkg::t_item                        i_item,
    output logic                                  o_valid,
    output logic [swq_pkg::N_INF-1:0][7:0]        o_joint,
    output logic [swq_pkg::N_INF-1:0][7:0]        o_weight
);
    import swq_pkg::*;

    logic                   r_valid;
    logic [N_INF-1:0][7:0]  r_joint;
    logic [N_INF-1:0][7:0]  r_weight;
    logic [N_INF-1:0][7:0]  n_joint;
    logic [N_INF-1:0][7:0]  n_weight;

    always_comb begin
        logic [9:0]        total;
        logic [9:0]        left;
        logic [2:0]        rank;
        logic [Q_BITS-1:0] qv;
        total = '0;
        for (int l = 0; l < N_INF; l++) begin
            total = total + 10'(i_item.q[l]);
        end
        left = 10'(FULL_SCALE) - total;
        for (int l = 0; l < N_INF; l++) begin
            // lanes ahead in the remainder order, ties to the lower position
            rank = '0;
            for (int k = 0; k < N_INF; k++) begin
                if (k != l) begin
                    if ((i_item.rem[k] > i_item.rem[l]) ||
                        ((i_item.rem[k] == i_item.rem[l]) && (k < l))) begin
                        rank = rank + 3'd1;
                    end
                end
            end
            qv = i_item.q[l];
            if (10'(rank) < left) begin
                qv = qv + 8'd1;
            end
            if (i_item.sum == '0) begin
                n_weight[l] = (l == 0) ? 8'(FULL_SCALE) : 8'd0;
                n_joint[l]  = 8'd0;
            end else begin
                n_weight[l] = qv;
                n_joint[l]  = (qv != '0) ? i_item.joint[l] : 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_item.valid;
        end
        r_joint  <= n_joint;
        r_weight <= n_weight;
    end

    assign o_valid  = r_valid;
    assign o_joint  = r_joint;
    assign o_weight = r_weight;

endmodule

// ----- src/skin_weight_quantizer_top.sv -----
// top level of the skin weight quantizer
// takes one vertex request in every cycle (busy stays low) and delivers its
// quantized influences as a one-cycle o_valid strobe after passing through the
// clamp and sort stages, eight division cells (one quotient bit each) and
// the remainder distribution stage. results cannot be stalled.
module skin_weight_quantizer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_joint_in_0,
    input  logic [15:0] i_joint_in_1,
    input  logic [15:0] i_joint_in_2,
    input  logic [15:0] i_joint_in_3,
    input  logic signed [15:0] i_weight_in_0,
    input  logic signed [15:0] i_weight_in_1,
    input  logic signed [15:0] i_weight_in_2,
    input  logic signed [15:0] i_weight_in_3,
    output logic        o_valid,
    output logic [7:0]  o_joint_out_0,
    output logic [7:0]  o_joint_out_1,
    output logic [7:0]  o_joint_out_2,
    output logic [7:0]  o_joint_out_3,
    output logic [7:0]  o_weight_out_0,
    output logic [7:0]  o_weight_out_1,
    output logic [7:0]  o_weight_out_2,
    output logic [7:0]  o_weight_out_3
);
    import swq_pkg::*;

    logic [N_INF-1:0][15:0] s_joint;
    logic [N_INF-1:0][15:0] s_weight;
    logic [N_INF-1:0][7:0]  s_jout;
    logic [N_INF-1:0][7:0]  s_wout;
    t_item                  s_chain [Q_BITS+1];

    assign busy = 1'b0;

    assign s_joint  = {i_joint_in_3, i_joint_in_2, i_joint_in_1, i_joint_in_0};
    assign s_weight = {i_weight_in_3, i_weight_in_2, i_weight_in_1, i_weight_in_0};

    swq_sort u_sort (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start),
        .i_joint  (s_joint),
        .i_weight (s_weight),
        .o_item   (s_chain[0])
    );

    // most significant quotient bit first
    for (genvar g = 0; g < Q_BITS; g++) begin : g_div
        swq_div_cell #(
            .BIT (Q_BITS - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_item  (s_chain[g]),
            .o_item  (s_chain[g+1])
        );
    end

    swq_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (s_chain[Q_BITS]),
        .o_valid  (o_valid),
        .o_joint  (s_jout),
        .o_weight (s_wout)
    );

    assign o_joint_out_0  = s_jout[0];
    assign o_joint_out_1  = s_jout[1];
    assign o_joint_out_2  = s_jout[2];
    assign o_joint_out_3  = s_jout[3];
    assign o_weight_out_0 = s_wout[0];
    assign o_weight_out_1 = s_wout[1];
    assign o_weight_out_2 = s_wout[2];
    assign o_weight_out_3 = s_wout[3];

endmodule
